>>> hdl/utfom_pkg.sv
// shared types and constants for the uart transmit ring buffer
// no dependencies; used by utfom_ctrl and the top level
package utfom_pkg;

  // ring depth used when the top level is not overridden
  localparam int DEPTH_DEF = 256;

  // byte stored in place of the offered one when a single slot is left
  localparam logic [7:0] MARK_BYTE = 8'h21;

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] push_byte;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       pop_valid;
    logic [7:0] pop_byte;
    logic       ready_request;
    logic [7:0] free_slots;
  } out_item_t;

endpackage

>>> hdl/utfom_mem.sv
// byte storage of the ring: one write port, one read port with registered data
// depends on nothing but its parameters
module utfom_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/utfom_ctrl.sv
// pointer, free count and request flag control of the ring, plus result register
// uses utfom_pkg; drives the write and read ports of utfom_mem
module utfom_ctrl #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  utfom_pkg::in_item_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                res_accepted,
  output logic                res_pop_valid,
  output logic                res_ready_request,
  output logic [7:0]          res_free_slots,
  output logic                mem_wr_en,
  output logic [ADDR_W-1:0]   mem_wr_addr,
  output logic [7:0]          mem_wr_data,
  output logic                mem_rd_en,
  output logic [ADDR_W-1:0]   mem_rd_addr
);

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] ONE      = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] TWO      = ADDR_W'(2);
  localparam int                FS_W     = (ADDR_W > 8) ? ADDR_W : 8;

  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W-1:0] free_r, free_nxt;
  logic              req_en_r, req_en_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              acc_r, acc_nxt;
  logic              pv_r, pv_nxt;

  logic              in_acc;
  logic              is_push;
  logic              empty;
  logic              do_store;
  logic              do_pop;
  logic [FS_W-1:0]   free_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign is_push  = (in_data.cmd == utfom_pkg::CMD_PUSH);
  assign empty    = (free_r == LAST_IDX);

  // store on push whenever at least one slot is left
  assign do_store = in_acc && is_push && (free_r != '0);
  assign do_pop   = in_acc && !is_push && !empty;

  assign mem_wr_en   = do_store;
  assign mem_wr_addr = wr_ptr_r;
  assign mem_wr_data = (free_r >= TWO) ? in_data.push_byte : utfom_pkg::MARK_BYTE;
  assign mem_rd_en   = do_pop;
  assign mem_rd_addr = rd_ptr_r;

  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    free_nxt      = free_r;
    req_en_nxt    = req_en_r;
    acc_nxt       = acc_r;
    pv_nxt        = pv_r;
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      acc_nxt       = is_push && (free_r >= TWO);
      pv_nxt        = do_pop;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (do_store) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + ONE;
      free_nxt   = free_r - ONE;
      req_en_nxt = 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + ONE;
      free_nxt   = free_r + ONE;
    end
    if (in_acc && !is_push && empty) begin
      req_en_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      free_r      <= LAST_IDX;
      req_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      free_r      <= free_nxt;
      req_en_r    <= req_en_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      pv_r        <= pv_nxt;
    end
  end

  // flag and free count only move on an accepted item, so they describe the held result
  assign free_ext          = FS_W'(free_r);
  assign out_valid         = out_valid_r;
  assign res_accepted      = acc_r;
  assign res_pop_valid     = pv_r;
  assign res_ready_request = req_en_r;
  assign res_free_slots    = free_ext[7:0];

  // free count never goes above the ring capacity
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= LAST_IDX)
    else $error("free count above capacity");

  // pointers and free count agree: equal pointers exactly when empty
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r == rd_ptr_r) == empty)
    else $error("pointers disagree with free count");

  // any store raises the request flag
  a_store_flag: assert property (@(posedge clk) disable iff (!rst_n)
    do_store |=> req_en_r)
    else $error("store did not set request flag");

  // a pop on an empty ring clears the flag and returns no byte
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_push && empty) |=> (!req_en_r && !pv_r))
    else $error("empty pop mishandled");

  // a result never reports both a stored push and a popped byte
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(acc_r && pv_r))
    else $error("accepted and pop_valid both set");

endmodule

>>> hdl/uart_tx_fifo_overrun_marker.sv
// top level of the uart transmit ring buffer with overrun marker
// uses utfom_pkg, utfom_ctrl and utfom_mem
//
// usage
//   in_*  channel: one item per handshake; cmd selects push (offer push_byte)
//         or pop (transmitter ready, take the oldest byte)
//   out_* channel: exactly one result item per input item, in order
//   a push with two or more free slots stores the byte (accepted = 1); with
//   exactly one free slot the marker byte '!' is stored instead (accepted = 0);
//   with the ring full nothing is stored
//   a pop returns the oldest byte with pop_valid = 1, or pop_valid = 0 and
//   pop_byte = 0 when empty, in which case ready_request is cleared
//   the ring holds at most DEPTH - 1 bytes; free_slots gives the low 8 bits
//   of the free count after the item
// timing
//   out_valid rises in the cycle after the input handshake; one item per cycle
//   sustained while out_ready is high, set by the pointer update and the
//   registered read of the byte memory
// reset
//   rst_n low (synchronous) empties the ring and clears ready_request; the
//   byte memory is not cleared and needs no sweep
// stall
//   with out_ready low the result is held in the output register and in_ready
//   drops; a new item is taken in the same cycle the held result leaves
module uart_tx_fifo_overrun_marker #(
  parameter int DEPTH = utfom_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  utfom_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utfom_pkg::out_item_t out_data
);

  localparam int ADDR_W = $clog2(DEPTH);

  // memory port signals
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [7:0]        mem_wr_data;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [7:0]        mem_rd_data;

  // registered result fields from control
  logic              res_accepted;
  logic              res_pop_valid;
  logic              res_ready_request;
  logic [7:0]        res_free_slots;

  utfom_ctrl #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .res_accepted      (res_accepted),
    .res_pop_valid     (res_pop_valid),
    .res_ready_request (res_ready_request),
    .res_free_slots    (res_free_slots),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data),
    .mem_rd_en         (mem_rd_en),
    .mem_rd_addr       (mem_rd_addr)
  );

  // the read data register only loads on a real pop, so it holds during a stall
  utfom_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // pop_byte reads as zero on a push and on an empty pop
  always_comb begin
    out_data.accepted      = res_accepted;
    out_data.pop_valid     = res_pop_valid;
    out_data.pop_byte      = res_pop_valid ? mem_rd_data : 8'h00;
    out_data.ready_request = res_ready_request;
    out_data.free_slots    = res_free_slots;
  end

endmodule
